### src/fpo_pkg.sv
// Shared types, constants and helper functions of the planar odometry block.
// Depends on nothing; every other file of the block uses it.
package fpo_pkg;

	// Datapath widths of the shared units.
	localparam int ACC_W = 70;
	localparam int A_W = 34;
	localparam int B_W = 36;
	localparam int DIG_W = 4;
	localparam int CNT_W = 4;
	localparam int CZ_W = 34;
	localparam int CS_W = 32;
	localparam int SQ_W = 64;

	// Digit counts of the multiplier operands (each digit is four bits).
	localparam logic [CNT_W-1:0] ND_VEL = 4'd6;
	localparam logic [CNT_W-1:0] ND_WT = 4'd5;
	localparam logic [CNT_W-1:0] ND_DT = 4'd6;
	localparam logic [CNT_W-1:0] ND_CS = 4'd8;
	localparam logic [CNT_W-1:0] ND_DIST = 4'd9;

	// Configuration register indexes.
	localparam logic CFG_TRUST = 1'b0;
	localparam logic CFG_FUSION = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [19:0] dt;
		logic signed [15:0] imu_heading;
		logic signed [23:0] body_vx;
		logic signed [23:0] body_vy;
		logic signed [23:0] accel_vx;
		logic signed [23:0] accel_vy;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [15:0] pose_heading;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading_out;
		logic signed [31:0] forward_dist;
		logic signed [31:0] lateral_dist;
		logic [30:0] straight_dist;
	} result_t;

	// One request to the digit-serial multiply-accumulate unit.
	typedef struct packed {
		logic start;
		logic clr;
		logic sub;
		logic signed [A_W-1:0] a;
		logic signed [B_W-1:0] b;
		logic [CNT_W-1:0] ndig;
	} mac_req_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_HCOR, ST_VX0, ST_VX1, ST_VY0, ST_VY1,
		ST_BX0, ST_BX1, ST_BY0, ST_BY1, ST_PX, ST_PY, ST_OCOR,
		ST_FW0, ST_FW1, ST_LT0, ST_LT1, ST_SQX, ST_SQY, ST_SQRT, ST_OUT
	} state_t;

	// Arctangent of 2^-i in units of 2^32 per turn.
	function automatic logic [CZ_W-1:0] atan_entry(input logic [4:0] i);
		logic [CZ_W-1:0] v;
		case (i)
			5'd0: v = 34'h020000000;
			5'd1: v = 34'h012E4051E;
			5'd2: v = 34'h009FB385B;
			5'd3: v = 34'h0051111D4;
			5'd4: v = 34'h0028B0D43;
			5'd5: v = 34'h00145D7E1;
			5'd6: v = 34'h000A2F61E;
			5'd7: v = 34'h000517C55;
			5'd8: v = 34'h00028BE53;
			5'd9: v = 34'h000145F2F;
			5'd10: v = 34'h0000A2F98;
			5'd11: v = 34'h0000517CC;
			5'd12: v = 34'h000028BE6;
			5'd13: v = 34'h0000145F3;
			5'd14: v = 34'h00000A2FA;
			5'd15: v = 34'h00000517D;
			5'd16: v = 34'h0000028BE;
			5'd17: v = 34'h00000145F;
			5'd18: v = 34'h000000A30;
			5'd19: v = 34'h000000518;
			5'd20: v = 34'h00000028C;
			5'd21: v = 34'h000000146;
			5'd22: v = 34'h0000000A3;
			5'd23: v = 34'h000000051;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Saturate a wide signed value to the int32 range.
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### src/fpo_ifs.sv
// Valid/ready channel interfaces for input items and result words.
// Depends on fpo_pkg for the payload structs.
interface fpo_item_if;
	logic valid;
	logic ready;
	fpo_pkg::item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fpo_result_if;
	logic valid;
	logic ready;
	fpo_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### src/fpo_mac.sv
// Digit-serial signed multiply-accumulate unit, four multiplier bits per cycle.
// Depends on fpo_pkg.
module fpo_mac (
	input logic clk,
	input logic arst_n,
	input fpo_pkg::mac_req_t req,
	output logic signed [fpo_pkg::ACC_W-1:0] acc,
	output logic done
);
	logic signed [fpo_pkg::ACC_W-1:0] a_q;
	logic signed [fpo_pkg::ACC_W-1:0] acc_q;
	logic signed [fpo_pkg::ACC_W-1:0] prod;
	logic signed [fpo_pkg::B_W-1:0] b_q;
	logic [fpo_pkg::CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic sub_q;
	logic signed [fpo_pkg::DIG_W:0] dig;

	// The last digit carries the sign of the multiplier.
	assign dig = (cnt_q == fpo_pkg::CNT_W'(1)) ? {b_q[fpo_pkg::DIG_W-1], b_q[fpo_pkg::DIG_W-1:0]}
		: {1'b0, b_q[fpo_pkg::DIG_W-1:0]};
	assign prod = a_q * {{(fpo_pkg::ACC_W-fpo_pkg::DIG_W-1){dig[fpo_pkg::DIG_W]}}, dig};

	// Control: digit counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.ndig;
			end else if (busy_q) begin
				cnt_q <= cnt_q - fpo_pkg::CNT_W'(1);
				if (cnt_q == fpo_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the operands one digit and accumulate the partial product.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= {{(fpo_pkg::ACC_W-fpo_pkg::A_W){req.a[fpo_pkg::A_W-1]}}, req.a};
			b_q <= req.b;
			sub_q <= req.sub;
			if (req.clr) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			acc_q <= sub_q ? acc_q - prod : acc_q + prod;
			a_q <= a_q <<< fpo_pkg::DIG_W;
			b_q <= b_q >>> fpo_pkg::DIG_W;
		end
	end

	assign acc = acc_q;
	assign done = done_q;
endmodule

### src/fpo_cordic.sv
// Iterative CORDIC sine and cosine, one rotation step per cycle, Q1.30 results.
// Depends on fpo_pkg for the arctangent table.
module fpo_cordic #(
	parameter int STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] angle,
	output logic signed [fpo_pkg::CS_W-1:0] cos_val,
	output logic signed [fpo_pkg::CS_W-1:0] sin_val,
	output logic done
);
	localparam logic signed [fpo_pkg::CZ_W-1:0] GAIN = 34'sd652032874;
	localparam logic signed [fpo_pkg::CZ_W-1:0] LIM = 34'sd1073741824;

	logic signed [fpo_pkg::CZ_W-1:0] x_q, y_q, z_q;
	logic signed [fpo_pkg::CZ_W-1:0] xs, ys, at, xn, yn;
	logic [4:0] i_q;
	logic busy_q, done_q, neg_q;
	logic signed [15:0] a_in, a_fold;
	logic fold;

	// Fold angles beyond a quarter turn by a half turn.
	assign a_in = angle;
	always_comb begin
		fold = 1'b0;
		a_fold = a_in;
		if (a_in > 16'sd16384) begin
			fold = 1'b1;
			a_fold = a_in - 16'sh8000;
		end else if (a_in < -16'sd16384) begin
			fold = 1'b1;
			a_fold = a_in + 16'sh8000;
		end
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = fpo_pkg::atan_entry(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One rotation step toward zero residual angle.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= GAIN;
			y_q <= '0;
			z_q <= {{(fpo_pkg::CZ_W-32){a_fold[15]}}, a_fold, 16'h0000};
			neg_q <= fold;
		end else if (busy_q) begin
			if (!z_q[fpo_pkg::CZ_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	// Undo the fold and clamp to the unit range.
	always_comb begin
		xn = neg_q ? -x_q : x_q;
		yn = neg_q ? -y_q : y_q;
		if (xn > LIM) xn = LIM;
		else if (xn < -LIM) xn = -LIM;
		if (yn > LIM) yn = LIM;
		else if (yn < -LIM) yn = -LIM;
	end

	assign cos_val = xn[fpo_pkg::CS_W-1:0];
	assign sin_val = yn[fpo_pkg::CS_W-1:0];
	assign done = done_q;
endmodule

### src/fpo_sqrt.sv
// Bit-serial integer square root, one result bit per cycle, rounded to nearest.
// Depends on fpo_pkg for widths.
module fpo_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [fpo_pkg::SQ_W-1:0] val,
	output logic [32:0] root,
	output logic done
);
	logic [fpo_pkg::SQ_W-1:0] n_q, r_q, bit_q, trial;
	logic [4:0] cnt_q;
	logic busy_q, done_q;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring step on one pair of radicand bits.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= val;
			r_q <= '0;
			bit_q <= {2'b01, {(fpo_pkg::SQ_W-2){1'b0}}};
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q <= n_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// Round to nearest: bump when the remainder exceeds the root.
	assign root = r_q[32:0] + {32'd0, (n_q > r_q)};
	assign done = done_q;
endmodule

### src/fused_planar_odometry_top.sv
// Top level of the planar dead-reckoning integrator with wheel/accelerometer blending.
// Depends on fpo_pkg, fpo_ifs, fpo_mac, fpo_cordic and fpo_sqrt.
//
// One word in gives one result word out. Items are handled one at a time by a
// sequencer that drives three shared serial units: a CORDIC (CORDIC_STEPS steps,
// one per cycle, run for the heading on an update and for the origin angle on
// every word), a multiply-accumulate that takes four multiplier bits per cycle,
// and a square root that takes one root bit per cycle. A finished result waits
// in an output register, so the next word is taken while it is still pending.
module fused_planar_odometry_top #(
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_idx,
	input logic [16:0] cfg_data,
	fpo_item_if.sink item,
	fpo_result_if.source result
);
	fpo_pkg::state_t state_q, state_d;
	logic pend_q;
	logic item_acc, upd_go, unit_done;

	// Configuration.
	logic [16:0] trust_q;
	logic fus_en_q;

	// Architectural state.
	logic signed [31:0] pos_x_q, pos_y_q, org_x_q, org_y_q;
	logic [15:0] org_ang_q, first_q, latest_q;
	logic seen_q, armed_q, blend_q;

	// Latched item payload and intermediate results.
	logic signed [23:0] bx_q, by_q, ax_q, ay_q;
	logic [19:0] dt_q;
	logic signed [25:0] vx_q, vy_q;
	logic signed [31:0] fwd_q, lat_q;
	logic [30:0] str_q;
	fpo_pkg::result_t out_q;
	logic out_vld_q, out_load;

	// Unit connections.
	fpo_pkg::mac_req_t mreq;
	logic signed [fpo_pkg::ACC_W-1:0] macc, rnd30, rnd20, rnd16;
	logic mac_done, cor_start, cor_done, sq_start, sq_done;
	logic [15:0] cor_ang, cur_hdg;
	logic signed [31:0] cor_c, cor_s;
	logic [32:0] sq_root;
	logic signed [32:0] dx, dy;
	logic big;
	logic [16:0] wt, inv_wt;
	logic signed [39:0] pos_x_sum, pos_y_sum;

	fpo_mac u_mac (
		.clk(clk), .arst_n(arst_n), .req(mreq), .acc(macc), .done(mac_done)
	);

	fpo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .angle(cor_ang),
		.cos_val(cor_c), .sin_val(cor_s), .done(cor_done)
	);

	fpo_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .val(macc[fpo_pkg::SQ_W-1:0]),
		.root(sq_root), .done(sq_done)
	);

	assign item_acc = item.valid && item.ready;
	assign upd_go = !item.data.cmd && (item.data.dt != 20'd0);
	assign unit_done = mac_done || cor_done || sq_done;
	assign cur_hdg = seen_q ? (org_ang_q + latest_q - first_q) : org_ang_q;

	// Displacement from the origin and the overflow test for the distance.
	assign dx = 33'(pos_x_q) - 33'(org_x_q);
	assign dy = 33'(pos_y_q) - 33'(org_y_q);
	assign big = (dx[32] != dx[31]) || (dx[32:31] == 2'b11 && dx[30:0] == '0)
		|| (dy[32] != dy[31]) || (dy[32:31] == 2'b11 && dy[30:0] == '0);

	// Blend weights, with the trust capped at one.
	assign wt = (trust_q > 17'd65536) ? 17'd65536 : trust_q;
	assign inv_wt = 17'd65536 - wt;

	// Round-half-up reductions of the accumulator.
	assign rnd30 = (macc + (fpo_pkg::ACC_W'(1) <<< 29)) >>> 30;
	assign rnd20 = (macc + (fpo_pkg::ACC_W'(1) <<< 19)) >>> 20;
	assign rnd16 = (macc + (fpo_pkg::ACC_W'(1) <<< 15)) >>> 16;
	assign pos_x_sum = 40'(pos_x_q) + rnd20[39:0];
	assign pos_y_sum = 40'(pos_y_q) + rnd20[39:0];

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fpo_pkg::ST_IDLE: if (item_acc) begin
				state_d = upd_go ? fpo_pkg::ST_HCOR : fpo_pkg::ST_OCOR;
			end
			fpo_pkg::ST_HCOR: if (unit_done) state_d = fpo_pkg::ST_VX0;
			fpo_pkg::ST_VX0: if (unit_done) state_d = fpo_pkg::ST_VX1;
			fpo_pkg::ST_VX1: if (unit_done) state_d = fpo_pkg::ST_VY0;
			fpo_pkg::ST_VY0: if (unit_done) state_d = fpo_pkg::ST_VY1;
			fpo_pkg::ST_VY1: if (unit_done) begin
				state_d = blend_q ? fpo_pkg::ST_BX0 : fpo_pkg::ST_PX;
			end
			fpo_pkg::ST_BX0: if (unit_done) state_d = fpo_pkg::ST_BX1;
			fpo_pkg::ST_BX1: if (unit_done) state_d = fpo_pkg::ST_BY0;
			fpo_pkg::ST_BY0: if (unit_done) state_d = fpo_pkg::ST_BY1;
			fpo_pkg::ST_BY1: if (unit_done) state_d = fpo_pkg::ST_PX;
			fpo_pkg::ST_PX: if (unit_done) state_d = fpo_pkg::ST_PY;
			fpo_pkg::ST_PY: if (unit_done) state_d = fpo_pkg::ST_OCOR;
			fpo_pkg::ST_OCOR: if (unit_done) state_d = fpo_pkg::ST_FW0;
			fpo_pkg::ST_FW0: if (unit_done) state_d = fpo_pkg::ST_FW1;
			fpo_pkg::ST_FW1: if (unit_done) state_d = fpo_pkg::ST_LT0;
			fpo_pkg::ST_LT0: if (unit_done) state_d = fpo_pkg::ST_LT1;
			fpo_pkg::ST_LT1: if (unit_done) state_d = fpo_pkg::ST_SQX;
			fpo_pkg::ST_SQX: if (unit_done) state_d = fpo_pkg::ST_SQY;
			fpo_pkg::ST_SQY: if (unit_done) begin
				state_d = big ? fpo_pkg::ST_OUT : fpo_pkg::ST_SQRT;
			end
			fpo_pkg::ST_SQRT: if (unit_done) state_d = fpo_pkg::ST_OUT;
			fpo_pkg::ST_OUT: if (out_load) state_d = fpo_pkg::ST_IDLE;
			default: state_d = fpo_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: unit launches and operand selection.
	always_comb begin
		item.ready = (state_q == fpo_pkg::ST_IDLE);
		cor_start = 1'b0;
		cor_ang = org_ang_q;
		sq_start = 1'b0;
		mreq.start = 1'b0;
		mreq.clr = 1'b1;
		mreq.sub = 1'b0;
		mreq.a = fpo_pkg::A_W'(dx);
		mreq.b = fpo_pkg::B_W'(dx);
		mreq.ndig = fpo_pkg::ND_DIST;
		case (state_q)
			fpo_pkg::ST_HCOR: begin
				cor_start = !pend_q;
				cor_ang = cur_hdg;
			end
			fpo_pkg::ST_OCOR: begin
				cor_start = !pend_q;
			end
			fpo_pkg::ST_VX0: begin
				mreq.start = !pend_q;
				mreq.a = fpo_pkg::A_W'(cor_c);
				mreq.b = fpo_pkg::B_W'(bx_q);
				mreq.ndig = fpo_pkg::ND_VEL;
			end
			fpo_pkg::ST_VX1: begin
				mreq.start = !pend_q;
				mreq.clr = 1'b0;
				mreq.sub = 1'b1;
				mreq.a = fpo_pkg::A_W'(cor_s);
				mreq.b = fpo_pkg::B_W'(by_q);
				mreq.ndig = fpo_pkg::ND_VEL;
			end
			fpo_pkg::ST_VY0: begin
				mreq.start = !pend_q;
				mreq.a = fpo_pkg::A_W'(cor_s);
				mreq.b = fpo_pkg::B_W'(bx_q);
				mreq.ndig = fpo_pkg::ND_VEL;
			end
			fpo_pkg::ST_VY1: begin
				mreq.start = !pend_q;
				mreq.clr = 1'b0;
				mreq.a = fpo_pkg::A_W'(cor_c);
				mreq.b = fpo_pkg::B_W'(by_q);
				mreq.ndig = fpo_pkg::ND_VEL;
			end
			fpo_pkg::ST_BX0: begin
				mreq.start = !pend_q;
				mreq.a = fpo_pkg::A_W'(vx_q);
				mreq.b = fpo_pkg::B_W'({1'b0, wt});
				mreq.ndig = fpo_pkg::ND_WT;
			end
			fpo_pkg::ST_BX1: begin
				mreq.start = !pend_q;
				mreq.clr = 1'b0;
				mreq.a = fpo_pkg::A_W'(ax_q);
				mreq.b = fpo_pkg::B_W'({1'b0, inv_wt});
				mreq.ndig = fpo_pkg::ND_WT;
			end
			fpo_pkg::ST_BY0: begin
				mreq.start = !pend_q;
				mreq.a = fpo_pkg::A_W'(vy_q);
				mreq.b = fpo_pkg::B_W'({1'b0, wt});
				mreq.ndig = fpo_pkg::ND_WT;
			end
			fpo_pkg::ST_BY1: begin
				mreq.start = !pend_q;
				mreq.clr = 1'b0;
				mreq.a = fpo_pkg::A_W'(ay_q);
				mreq.b = fpo_pkg::B_W'({1'b0, inv_wt});
				mreq.ndig = fpo_pkg::ND_WT;
			end
			fpo_pkg::ST_PX: begin
				mreq.start = !pend_q;
				mreq.a = fpo_pkg::A_W'(vx_q);
				mreq.b = fpo_pkg::B_W'({1'b0, dt_q});
				mreq.ndig = fpo_pkg::ND_DT;
			end
			fpo_pkg::ST_PY: begin
				mreq.start = !pend_q;
				mreq.a = fpo_pkg::A_W'(vy_q);
				mreq.b = fpo_pkg::B_W'({1'b0, dt_q});
				mreq.ndig = fpo_pkg::ND_DT;
			end
			fpo_pkg::ST_FW0: begin
				mreq.start = !pend_q;
				mreq.a = fpo_pkg::A_W'(dx);
				mreq.b = fpo_pkg::B_W'(cor_c);
				mreq.ndig = fpo_pkg::ND_CS;
			end
			fpo_pkg::ST_FW1: begin
				mreq.start = !pend_q;
				mreq.clr = 1'b0;
				mreq.a = fpo_pkg::A_W'(dy);
				mreq.b = fpo_pkg::B_W'(cor_s);
				mreq.ndig = fpo_pkg::ND_CS;
			end
			fpo_pkg::ST_LT0: begin
				mreq.start = !pend_q;
				mreq.a = fpo_pkg::A_W'(dy);
				mreq.b = fpo_pkg::B_W'(cor_c);
				mreq.ndig = fpo_pkg::ND_CS;
			end
			fpo_pkg::ST_LT1: begin
				mreq.start = !pend_q;
				mreq.clr = 1'b0;
				mreq.sub = 1'b1;
				mreq.a = fpo_pkg::A_W'(dx);
				mreq.b = fpo_pkg::B_W'(cor_s);
				mreq.ndig = fpo_pkg::ND_CS;
			end
			fpo_pkg::ST_SQX: begin
				mreq.start = !pend_q;
			end
			fpo_pkg::ST_SQY: begin
				mreq.start = !pend_q;
				mreq.clr = 1'b0;
				mreq.a = fpo_pkg::A_W'(dy);
				mreq.b = fpo_pkg::B_W'(dy);
			end
			fpo_pkg::ST_SQRT: begin
				sq_start = !pend_q;
			end
			default: begin
			end
		endcase
	end

	assign out_load = (state_q == fpo_pkg::ST_OUT) && (!out_vld_q || result.ready);

	// Control registers: state, unit handshake, output valid, configuration, pose and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpo_pkg::ST_IDLE;
			pend_q <= 1'b0;
			out_vld_q <= 1'b0;
			trust_q <= 17'd65536;
			fus_en_q <= 1'b0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			org_x_q <= '0;
			org_y_q <= '0;
			org_ang_q <= '0;
			first_q <= '0;
			latest_q <= '0;
			seen_q <= 1'b0;
			armed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mreq.start || cor_start || sq_start) begin
				pend_q <= 1'b1;
			end else if (unit_done) begin
				pend_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_idx)
					fpo_pkg::CFG_TRUST: trust_q <= cfg_data;
					fpo_pkg::CFG_FUSION: fus_en_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			// Word acceptance: reset to pose, or latch the heading reference.
			if (item_acc) begin
				if (item.data.cmd) begin
					pos_x_q <= item.data.pose_x;
					pos_y_q <= item.data.pose_y;
					org_x_q <= item.data.pose_x;
					org_y_q <= item.data.pose_y;
					org_ang_q <= item.data.pose_heading;
					seen_q <= 1'b0;
					armed_q <= 1'b0;
				end else if (upd_go) begin
					if (!seen_q) begin
						first_q <= item.data.imu_heading;
					end
					seen_q <= 1'b1;
					latest_q <= item.data.imu_heading;
					armed_q <= 1'b1;
				end
			end
			// Position integration.
			if (unit_done && state_q == fpo_pkg::ST_PX) begin
				pos_x_q <= fpo_pkg::sat32(pos_x_sum);
			end
			if (unit_done && state_q == fpo_pkg::ST_PY) begin
				pos_y_q <= fpo_pkg::sat32(pos_y_sum);
			end
		end
	end

	// Payload registers: latched word fields, intermediate results and the output word.
	always_ff @(posedge clk) begin
		if (item_acc) begin
			bx_q <= item.data.body_vx;
			by_q <= item.data.body_vy;
			ax_q <= item.data.accel_vx;
			ay_q <= item.data.accel_vy;
			dt_q <= item.data.dt;
			blend_q <= fus_en_q && armed_q;
		end
		if (unit_done) begin
			case (state_q)
				fpo_pkg::ST_VX1: vx_q <= rnd30[25:0];
				fpo_pkg::ST_VY1: vy_q <= rnd30[25:0];
				fpo_pkg::ST_BX1: vx_q <= rnd16[25:0];
				fpo_pkg::ST_BY1: vy_q <= rnd16[25:0];
				fpo_pkg::ST_FW1: fwd_q <= fpo_pkg::sat32(rnd30[39:0]);
				fpo_pkg::ST_LT1: lat_q <= fpo_pkg::sat32(rnd30[39:0]);
				fpo_pkg::ST_SQY: if (big) str_q <= 31'h7FFFFFFF;
				fpo_pkg::ST_SQRT: begin
					str_q <= (sq_root > 33'h07FFFFFFF) ? 31'h7FFFFFFF : sq_root[30:0];
				end
				default: begin
				end
			endcase
		end
		if (out_load) begin
			out_q.pos_x <= pos_x_q;
			out_q.pos_y <= pos_y_q;
			out_q.heading_out <= cur_hdg;
			out_q.forward_dist <= fwd_q;
			out_q.lateral_dist <= lat_q;
			out_q.straight_dist <= str_q;
		end
	end

	assign result.valid = out_vld_q;
	assign result.data = out_q;
endmodule

### test/tb_odometry_pred.sv
// Pose predictor and result scoreboard for the planar odometry testbench.
// Depends on fpo_pkg for the word and result structs.
package tb_odometry_pred;
	import fpo_pkg::*;

	class pose_scoreboard;
		// Predicted block state and settings.
		logic [16:0] trust;
		bit fusion_on;
		logic signed [31:0] px, py, ox, oy;
		logic [15:0] o_ang, imu_first, imu_last;
		bit imu_valid, blend_ready;
		result_t pending[$];
		int errors;

		function new();
			trust = 17'd65536;
			fusion_on = 0;
			px = 0; py = 0; ox = 0; oy = 0;
			o_ang = 0; imu_first = 0; imu_last = 0;
			imu_valid = 0; blend_ready = 0;
			errors = 0;
		endfunction

		function void write_reg(logic idx, logic [16:0] val);
			if (idx == CFG_TRUST) begin
				trust = val;
			end else begin
				fusion_on = val[0];
			end
		endfunction

		static function longint shr(longint v, int n);
			return v >>> n;
		endfunction

		static function longint round_shr(longint v, int n);
			return (v + (longint'(1) << (n - 1))) >>> n;
		endfunction

		static function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		static function longint clamp_q30(longint v);
			if (v > (64'sd1 << 30)) return 64'sd1 << 30;
			if (v < -(64'sd1 << 30)) return -(64'sd1 << 30);
			return v;
		endfunction

		static function longint atan_step(int i);
			longint tab[24] = '{
				'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
				'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
				'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
				'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
			return tab[i];
		endfunction

		// CORDIC cosine and sine of a binary angle, Q1.30.
		static function void cos_sin(logic [15:0] ang, output longint c, output longint s);
			longint a, x, y, z, xs, ys;
			bit flip;
			a = longint'($signed(ang));
			flip = 0;
			x = 652032874; y = 0;
			if (a > 16384) begin
				a -= 32768; flip = 1;
			end else if (a < -16384) begin
				a += 32768; flip = 1;
			end
			z = a * 65536;
			for (int i = 0; i < 16; i++) begin
				xs = shr(x, i); ys = shr(y, i);
				if (z >= 0) begin
					x -= ys; y += xs; z -= atan_step(i);
				end else begin
					x += ys; y -= xs; z += atan_step(i);
				end
			end
			if (flip) begin
				x = -x; y = -y;
			end
			c = clamp_q30(x);
			s = clamp_q30(y);
		endfunction

		static function longint root_nearest(longint unsigned v);
			longint unsigned r, b, n;
			r = 0; b = 64'd1 << 62; n = v;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b; r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			if (n > r) r++;
			return longint'(r);
		endfunction

		function logic [15:0] heading_now();
			return imu_valid ? 16'(o_ang + imu_last - imu_first) : o_ang;
		endfunction

		// Advance the prediction by one accepted word and queue its result.
		function void note_item(item_t it);
			longint c, s, vx, vy, bx, by, w, dx, dy, fwd, lat, span;
			result_t r;
			if (it.cmd) begin
				px = it.pose_x; py = it.pose_y; ox = it.pose_x; oy = it.pose_y;
				o_ang = it.pose_heading;
				imu_valid = 0; blend_ready = 0;
			end else if (it.dt != 0) begin
				bx = it.body_vx; by = it.body_vy;
				if (!imu_valid) begin
					imu_first = it.imu_heading; imu_valid = 1;
				end
				imu_last = it.imu_heading;
				cos_sin(heading_now(), c, s);
				vx = round_shr(c * bx - s * by, 30);
				vy = round_shr(s * bx + c * by, 30);
				if (fusion_on && blend_ready) begin
					w = (trust > 17'd65536) ? 65536 : longint'(trust);
					vx = round_shr(w * vx + (65536 - w) * longint'(it.accel_vx), 16);
					vy = round_shr(w * vy + (65536 - w) * longint'(it.accel_vy), 16);
				end
				blend_ready = 1;
				px = 32'(sat(longint'(px) + round_shr(vx * longint'(it.dt), 20)));
				py = 32'(sat(longint'(py) + round_shr(vy * longint'(it.dt), 20)));
			end
			dx = longint'(px) - longint'(ox);
			dy = longint'(py) - longint'(oy);
			cos_sin(o_ang, c, s);
			fwd = round_shr(dx * c + dy * s, 30);
			lat = round_shr(dy * c - dx * s, 30);
			if (dx >= (64'sd1 << 31) || dx <= -(64'sd1 << 31) ||
			    dy >= (64'sd1 << 31) || dy <= -(64'sd1 << 31)) begin
				span = 64'h7FFFFFFF;
			end else begin
				span = root_nearest(dx * dx + dy * dy);
				if (span > 64'h7FFFFFFF) span = 64'h7FFFFFFF;
			end
			r.pos_x = px; r.pos_y = py; r.heading_out = heading_now();
			r.forward_dist = 32'(sat(fwd)); r.lateral_dist = 32'(sat(lat));
			r.straight_dist = 31'(span);
			pending.push_back(r);
		endfunction

		// Compare one result word with the oldest prediction.
		function void check_result(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				$error("result word with no prediction waiting");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.pos_x !== e.pos_x) begin
				$error("pos_x expected %0d got %0d", e.pos_x, got.pos_x); errors++;
			end
			if (got.pos_y !== e.pos_y) begin
				$error("pos_y expected %0d got %0d", e.pos_y, got.pos_y); errors++;
			end
			if (got.heading_out !== e.heading_out) begin
				$error("heading_out expected %0d got %0d", e.heading_out, got.heading_out);
				errors++;
			end
			if (got.forward_dist !== e.forward_dist) begin
				$error("forward_dist expected %0d got %0d", e.forward_dist,
					got.forward_dist);
				errors++;
			end
			if (got.lateral_dist !== e.lateral_dist) begin
				$error("lateral_dist expected %0d got %0d", e.lateral_dist,
					got.lateral_dist);
				errors++;
			end
			if (got.straight_dist !== e.straight_dist) begin
				$error("straight_dist expected %0d got %0d", e.straight_dist,
					got.straight_dist);
				errors++;
			end
		endfunction
	endclass
endpackage

### test/tb_top.sv
// Top of the planar odometry testbench: clock, reset, word driver and result checker.
// Depends on fpo_pkg, fpo_ifs, tb_odometry_pred and the block's RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fpo_pkg::*;
	import tb_odometry_pred::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_idx = CFG_TRUST;
	logic [16:0] cfg_data = '0;
	int idle_cycles = 0;
	bit stim_done = 0;
	bit hold_sink = 0;
	pose_scoreboard sb = new();

	fpo_item_if item_ch();
	fpo_result_if result_ch();

	fused_planar_odometry_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .item(item_ch.sink), .result(result_ch.source)
	);

	always #1 clk = ~clk;

	initial begin
		item_ch.valid = 0;
		item_ch.data = '0;
		result_ch.ready = 0;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(3, 1);
		return $urandom_range(300, 20);
	endfunction

	function automatic logic signed [23:0] rand_vel();
		case ($urandom_range(4))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($signed($urandom_range(131072)) - 65536);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic item_t rand_update();
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		it.cmd = 0;
		it.body_vx = rand_vel(); it.body_vy = rand_vel();
		it.accel_vx = rand_vel(); it.accel_vy = rand_vel();
		case ($urandom_range(5))
			0: it.dt = 20'hFFFFF;
			1: it.dt = 0;
			2: it.dt = 20'($urandom_range(1000, 1));
			default: it.dt = 20'($urandom);
		endcase
		return it;
	endfunction

	function automatic item_t rand_reset();
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		it.cmd = 1;
		if ($urandom_range(1)) begin
			it.pose_x = 32'($signed($urandom_range(2000000)) - 1000000);
			it.pose_y = 32'($signed($urandom_range(2000000)) - 1000000);
		end
		return it;
	endfunction

	// Offer one word and hold it until it is accepted.
	task automatic send_word(item_t it);
		item_ch.data <= it;
		item_ch.valid <= 1;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic send_with_gap(item_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			item_ch.valid <= 0;
			repeat (g) @(negedge clk);
		end
		send_word(it);
	endtask

	// Drain all pending results, then let the block settle before a register write.
	task automatic wait_drained();
		item_ch.valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (260) @(negedge clk);
	endtask

	// One register write, with the write enable dropped again before the task returns.
	task automatic write_reg(logic idx, logic [16:0] val);
		cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// Stimulus.
	initial begin
		item_t it;
		logic [16:0] trusts[5] = '{17'd65536, 17'd0, 17'd131071, 17'd32768, 17'd1};
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// Directed: heading before any update, zero step, extremes, saturation.
		it = '0; it.cmd = 0; send_word(it);
		it = '0; it.cmd = 0; it.dt = 20'hFFFFF; it.imu_heading = 16'sh7FFF;
		it.body_vx = 24'sh7FFFFF; it.body_vy = 24'sh800000; send_word(it);
		it.imu_heading = 16'sh8000; send_word(it);
		it.imu_heading = 16'sh4000; it.body_vx = 24'sh800000; send_word(it);
		it = '0; it.cmd = 1; it.pose_x = 32'sh7FFFFF00; it.pose_y = 32'sh80000000;
		it.pose_heading = 16'sh8000; it.dt = 20'hFFFFF; send_word(it);
		it = '0; it.dt = 20'hFFFFF; it.body_vx = 24'sh7FFFFF;
		repeat (3) send_word(it);
		it = '0; it.cmd = 1; it.pose_x = 32'sh7FFFFFFF; it.pose_y = 32'sh7FFFFFFF;
		it.pose_heading = 16'sh2000; send_word(it);
		it = '0; it.dt = 20'hFFFFF; it.body_vx = 24'sh800000; it.body_vy = 24'sh800000;
		it.imu_heading = 16'sh2000;
		repeat (4) send_word(it);
		it = '0; it.cmd = 1; it.pose_heading = 16'sh4000; send_word(it);
		it = '0; it.dt = 20'd1; it.body_vy = 24'sd3; send_word(it);
		// Settings sweep with random words, both extremes among them.
		for (int ph = 0; ph < 10; ph++) begin
			wait_drained();
			write_reg(CFG_TRUST, trusts[ph % 5]);
			write_reg(CFG_FUSION, 17'(ph % 2 == 0 ? 1 : (ph == 9 ? 1 : 0)));
			if (ph == 4) hold_sink = 1;
			for (int k = 0; k < 48; k++) begin
				if ($urandom_range(15) == 0) it = rand_reset();
				else if ($urandom_range(40) == 0) begin
					it = rand_update(); it.cmd = 1;
				end else it = rand_update();
				if (ph == 2 || ph == 6) send_word(it);
				else send_with_gap(it);
			end
		end
		item_ch.valid <= 0;
		stim_done = 1;
	end

	// Receiver with random stalls and one long hold-off.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				result_ch.ready <= 0;
				repeat (2000) @(negedge clk);
				hold_sink = 0;
			end
			g = gap_len();
			if (g > 0 && $urandom_range(2) == 0) begin
				result_ch.ready <= 0;
				repeat (g) @(negedge clk);
			end
			result_ch.ready <= 1;
		end
	end

	// Result check and watchdog.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles > 20000);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

### filelist.f
src/fpo_pkg.sv
src/fpo_ifs.sv
src/fpo_mac.sv
src/fpo_cordic.sv
src/fpo_sqrt.sv
src/fused_planar_odometry_top.sv
test/tb_odometry_pred.sv
test/tb_top.sv
